// ===== rtl/core/u8d_pkg.sv =====
// u8d_pkg: types and constants shared by the utf-8 decoder modules
// no dependencies
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned CpWidth      = 21;
  localparam int unsigned PartialWidth = 15;
  localparam int unsigned QueueDepth   = 4;

  localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;

  // input beat: one raw byte of text
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_beat_t;

  // output beat: one decoded code point
  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               last_of_run;
  } out_beat_t;

  // all results caused by one input byte, one or two of them
  typedef struct packed {
    logic [CpWidth-1:0] cp_first;
    logic [CpWidth-1:0] cp_second;
    logic               two;
  } run_t;

  // what the front sends into the queue
  typedef struct packed {
    logic push;
    run_t run;
  } front_req_t;

  // what the queue shows to the back
  typedef struct packed {
    logic valid;
    run_t run;
  } queue_head_t;

endpackage

// ===== rtl/core/utf8_decoder_with_replacement.sv =====
// utf8_decoder_with_replacement: top level of the utf-8 decoder
// depends on u8d_pkg, u8d_front, u8d_queue, u8d_back
`timescale 1ns / 1ps

// usage
// - input side is a queue write port: a beat (one byte of text plus an
//   end of text flag) is taken at a clock edge with push high and full low
// - output side is a queue read port: while empty is low the oldest code
//   point sits on data_o, taken at an edge with pop high
// - each byte gives zero, one or two code points; last_of_run marks the
//   final one belonging to that byte, malformed pieces give U+FFFD
// - one byte a cycle is taken as long as the run queue has room; the
//   output side hands out one code point a cycle while pop is high, so a
//   byte with two results is handed out as two code points in turn
// - when the queue is empty, a taken byte's first code point reaches
//   data_o through a queue slot and then the output register
// - when the receiver stalls, runs collect in a DEPTH-entry queue behind
//   the output register; full rises once it is used up
// - reset clears the open sequence, the queue and the output register;
//   no clearing pass is needed, bytes are taken right after reset

module utf8_decoder_with_replacement import u8d_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_beat_t  data_i,
  output logic      empty,
  input  logic      pop,
  output out_beat_t data_o
);

  front_req_t  req;
  queue_head_t head;
  logic        head_pop;
  logic        accept;

  // a beat is only taken while the queue has a free slot
  assign accept = push && !full;

  u8d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (data_i),
    .req_o    (req)
  );

  u8d_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .pop_i  (head_pop),
    .full_o (full),
    .head_o (head)
  );

  // output register refills from the queue as its last result leaves
  u8d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .head_pop_o (head_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .data_o     (data_o)
  );

endmodule

// ===== rtl/core/u8d_front.sv =====
// u8d_front: accepts bytes, holds the open sequence and builds result runs
// depends on u8d_pkg
`timescale 1ns / 1ps

module u8d_front import u8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  in_beat_t   beat_i,
  output front_req_t req_o
);

  logic [PartialWidth-1:0] part_q, part_d;
  logic [1:0]              due_q, due_d;

  logic [7:0]              b;
  logic                    lead_emit;
  logic [CpWidth-1:0]      lead_cp;
  logic [PartialWidth-1:0] lead_part;
  logic [1:0]              lead_due;
  logic [CpWidth-1:0]      cont_v;
  logic [1:0]              next_due;
  logic [1:0]              cnt;
  logic [CpWidth-1:0]      cp_a, cp_b;

  assign b        = beat_i.data_byte;
  assign cont_v   = {part_q, b[5:0]};
  assign next_due = due_q - 2'd1;

  // lead byte decode, used with no sequence open and after a broken one
  always_comb begin
    lead_emit = 1'b0;
    lead_cp   = Replacement;
    lead_part = '0;
    lead_due  = 2'd0;
    priority if (b[7] == 1'b0) begin
      lead_emit = 1'b1;
      lead_cp   = {13'd0, b};
    end else if (b[7:5] == 3'b110) begin
      lead_part = {10'd0, b[4:0]};
      lead_due  = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      lead_part = {11'd0, b[3:0]};
      lead_due  = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      lead_part = {12'd0, b[2:0]};
      lead_due  = 2'd3;
    end else begin
      lead_emit = 1'b1;
    end
  end

  always_comb begin
    cnt    = 2'd0;
    cp_a   = Replacement;
    cp_b   = Replacement;
    part_d = part_q;
    due_d  = due_q;
    if (due_q == 2'd0) begin
      part_d = lead_part;
      due_d  = lead_due;
      if (lead_emit) begin
        cnt  = 2'd1;
        cp_a = lead_cp;
      end
    end else if (b[7:6] == 2'b10) begin
      if (next_due == 2'd0) begin
        cnt    = 2'd1;
        cp_a   = cont_v;
        part_d = '0;
        due_d  = 2'd0;
      end else begin
        part_d = cont_v[PartialWidth-1:0];
        due_d  = next_due;
      end
    end else begin
      // missing continuation: replacement, then the byte again as a lead
      cnt    = 2'd1;
      part_d = lead_part;
      due_d  = lead_due;
      if (lead_emit) begin
        cnt  = 2'd2;
        cp_b = lead_cp;
      end
    end
    // text ends inside a sequence
    if (beat_i.end_of_text && (due_d != 2'd0)) begin
      if (cnt == 2'd0) begin
        cnt  = 2'd1;
        cp_a = Replacement;
      end else begin
        cnt  = 2'd2;
        cp_b = Replacement;
      end
      part_d = '0;
      due_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      due_q  <= 2'd0;
    end else if (accept_i) begin
      part_q <= part_d;
      due_q  <= due_d;
    end
  end

  assign req_o.push          = accept_i && (cnt != 2'd0);
  assign req_o.run.cp_first  = cp_a;
  assign req_o.run.cp_second = cp_b;
  assign req_o.run.two       = (cnt == 2'd2);

endmodule

// ===== rtl/core/u8d_queue.sv =====
// u8d_queue: short queue of result runs between front and back
// depends on u8d_pkg
`timescale 1ns / 1ps

module u8d_queue import u8d_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  front_req_t  req_i,
  input  logic        pop_i,
  output logic        full_o,
  output queue_head_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  run_t            slot_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign do_pop = pop_i && (cnt_q != '0);
  assign full_o = (cnt_q == CntW'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      slot_q[wr_q] <= req_i.run;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (req_i.push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (req_i.push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !req_i.push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.run   = slot_q[rd_q];

endmodule

// ===== rtl/core/u8d_back.sv =====
// u8d_back: output register, hands out the results of one run in order
// depends on u8d_pkg
`timescale 1ns / 1ps

module u8d_back import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_head_t head_i,
  output logic        head_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output out_beat_t   data_o
);

  logic valid_q;
  logic sel_q;
  run_t run_q;
  logic last;
  logic take;

  assign last       = !run_q.two || sel_q;
  assign take       = pop_i && valid_q;
  assign head_pop_o = head_i.valid && (!valid_q || (take && last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (head_pop_o) begin
      valid_q <= 1'b1;
      sel_q   <= 1'b0;
    end else if (take) begin
      valid_q <= !last;
      sel_q   <= !last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_pop_o) begin
      run_q <= head_i.run;
    end
  end

  assign empty_o            = !valid_q;
  assign data_o.code_point  = sel_q ? run_q.cp_second : run_q.cp_first;
  assign data_o.last_of_run = last;

endmodule

// ===== rtl/core/u8d_checker.sv =====
// u8d_checker: port level checks on the utf-8 decoder, bound to the top level
// depends on u8d_pkg and utf8_decoder_with_replacement
`timescale 1ns / 1ps

module u8d_checker import u8d_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_beat_t data_o
);

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(data_o)))
    else $error("u8d: waiting result changed");

  // only a replacement can be followed by more results of the same byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !data_o.last_of_run) |-> (data_o.code_point == Replacement))
    else $error("u8d: non-final result is not a replacement");

  // no result appears on the output unless a byte was taken before it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && $past(empty) && !(push && !full) && !$past(push && !full)) |=> empty)
    else $error("u8d: result appeared from nothing");

  // nothing waits right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("u8d: output not empty after reset");

endmodule

bind utf8_decoder_with_replacement u8d_checker u_u8d_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .data_o (data_o)
);

// ===== tb/tb.sv =====
// tb: self-checking bench for utf8_decoder_with_replacement, byte stream in, code points out
// depends on u8d_pkg and the decoder rtl; needs no files or arguments
`timescale 1ns / 1ps

module tb;
  import u8d_pkg::*;

  localparam int unsigned DirRows    = 24;
  localparam int unsigned RandItems  = 1250;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned HoldCycles = 60;

  // how a table row is checked: literal results typed in, or the decoder model
  typedef enum logic {
    ByModel = 1'b0,
    Typed   = 1'b1
  } row_chk_e;

  typedef struct packed {
    logic [7:0]         data_v;
    logic               eot;
    row_chk_e           chk;
    logic [1:0]         n_cp;
    logic [CpWidth-1:0] cp_a;
    logic [CpWidth-1:0] cp_b;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_beat_t  data_i;
  logic      empty;
  logic      pop;
  out_beat_t data_o;

  utf8_decoder_with_replacement dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .data_i (data_i),
    .empty  (empty),
    .pop    (pop),
    .data_o (data_o)
  );

  // directed rows: extremes, each sequence length and the malformed cases
  stim_row_t dir_tab [DirRows] = '{
    '{8'h00, 1'b0, Typed,   2'd1, 21'h000000,  21'h0},  // lowest ascii
    '{8'h7F, 1'b0, Typed,   2'd1, 21'h00007F,  21'h0},  // highest ascii
    '{8'h80, 1'b0, Typed,   2'd1, Replacement, 21'h0},  // stray continuation as lead
    '{8'hFF, 1'b0, Typed,   2'd1, Replacement, 21'h0},  // bad lead, top of range
    '{8'hC2, 1'b0, Typed,   2'd0, 21'h0,       21'h0},  // two byte sequence
    '{8'hA9, 1'b0, ByModel, 2'd0, 21'h0,       21'h0},
    '{8'hE2, 1'b0, Typed,   2'd0, 21'h0,       21'h0},  // three byte sequence
    '{8'h82, 1'b0, Typed,   2'd0, 21'h0,       21'h0},
    '{8'hAC, 1'b0, ByModel, 2'd0, 21'h0,       21'h0},
    '{8'hF7, 1'b0, Typed,   2'd0, 21'h0,       21'h0},  // four byte, all ones
    '{8'hBF, 1'b0, Typed,   2'd0, 21'h0,       21'h0},
    '{8'hBF, 1'b0, Typed,   2'd0, 21'h0,       21'h0},
    '{8'hBF, 1'b0, Typed,   2'd1, 21'h1FFFFF,  21'h0},
    '{8'hC3, 1'b0, Typed,   2'd0, 21'h0,       21'h0},  // continuation missing, ascii follows
    '{8'h41, 1'b0, Typed,   2'd2, Replacement, 21'h000041},
    '{8'hE0, 1'b0, Typed,   2'd0, 21'h0,       21'h0},  // continuation missing, new lead only
    '{8'hC3, 1'b0, Typed,   2'd1, Replacement, 21'h0},
    '{8'hA9, 1'b0, ByModel, 2'd0, 21'h0,       21'h0},
    '{8'hE2, 1'b0, Typed,   2'd0, 21'h0,       21'h0},  // text ends inside a sequence
    '{8'h82, 1'b1, Typed,   2'd1, Replacement, 21'h0},
    '{8'hC3, 1'b0, Typed,   2'd0, 21'h0,       21'h0},  // missing continuation and text end
    '{8'hE2, 1'b1, Typed,   2'd2, Replacement, Replacement},
    '{8'hC0, 1'b0, Typed,   2'd0, 21'h0,       21'h0},  // overlong form decoded as is
    '{8'h80, 1'b0, ByModel, 2'd0, 21'h0,       21'h0}
  };

  stim_row_t   text_q [$];      // every byte of text to send, in order
  out_beat_t   pending_cps [$]; // code points still owed by the decoder
  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;
  int unsigned sent    = 0;
  bit          text_done = 1'b0;

  // decoder model state
  logic [PartialWidth-1:0] seq_bits;
  logic [1:0]              due_cnt;
  logic [CpWidth-1:0]      run_cp [2];
  int unsigned             run_n;

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  function automatic void emit_cp(logic [CpWidth-1:0] cp);
    run_cp[run_n] = cp;
    run_n++;
  endfunction

  // byte taken as a lead with no sequence open
  function automatic void open_lead(logic [7:0] b);
    if (!b[7]) begin
      emit_cp({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      seq_bits = {10'd0, b[4:0]};
      due_cnt  = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      seq_bits = {11'd0, b[3:0]};
      due_cnt  = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      seq_bits = {12'd0, b[2:0]};
      due_cnt  = 2'd3;
    end else begin
      emit_cp(Replacement);
    end
  endfunction

  // one byte in, zero to two code points out in run_cp
  function automatic void decode_byte(logic [7:0] b, logic eot);
    logic [CpWidth-1:0] acc;
    run_n = 0;
    if (due_cnt == 2'd0) begin
      seq_bits = '0;
      open_lead(b);
    end else if (b[7:6] == 2'b10) begin
      acc     = {seq_bits, b[5:0]};
      due_cnt = due_cnt - 2'd1;
      if (due_cnt == 2'd0) begin
        seq_bits = '0;
        emit_cp(acc);
      end else begin
        seq_bits = acc[PartialWidth-1:0];
      end
    end else begin
      // continuation missing: drop the sequence, the byte starts afresh
      emit_cp(Replacement);
      seq_bits = '0;
      due_cnt  = 2'd0;
      open_lead(b);
    end
    if (eot && due_cnt != 2'd0) begin
      emit_cp(Replacement);
      seq_bits = '0;
      due_cnt  = 2'd0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // random text
  // ---------------------------------------------------------------------------

  function automatic void add_text(logic [7:0] b);
    stim_row_t r;
    r        = '0;
    r.data_v = b;
    r.eot    = ($urandom_range(0, 15) == 0);
    r.chk    = ByModel;
    text_q.push_back(r);
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // mostly well formed sequences, the rest noise and cut short sequences
  function automatic void add_random_text();
    int unsigned pick;
    int unsigned len;
    int unsigned keep;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      add_text(8'($urandom_range(0, 127)));
    end else if (pick < 80) begin
      len = (pick < 48) ? 2 : (pick < 64) ? 3 : 4;
      case (len)
        2: add_text({3'b110, 5'($urandom_range(0, 31))});
        3: add_text({4'b1110, 4'($urandom_range(0, 15))});
        default: add_text({5'b11110, 3'($urandom_range(0, 7))});
      endcase
      for (int unsigned i = 1; i < len; i++) add_text(cont_byte());
    end else if (pick < 90) begin
      add_text(8'($urandom_range(0, 255)));
    end else begin
      // lead followed by too few continuations
      len  = $urandom_range(2, 4);
      keep = $urandom_range(0, len - 2);
      case (len)
        2: add_text({3'b110, 5'($urandom_range(0, 31))});
        3: add_text({4'b1110, 4'($urandom_range(0, 15))});
        default: add_text({5'b11110, 3'($urandom_range(0, 7))});
      endcase
      for (int unsigned i = 0; i < keep; i++) add_text(cont_byte());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset, cycle limit
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
  end

  initial begin
    wait (cyc_cnt >= CycleLimit);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sender: bursts of random length with random gaps
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned burst_left;
    int unsigned gap_left;
    push       <= 1'b0;
    data_i     <= '0;
    seq_bits    = '0;
    due_cnt     = 2'd0;
    burst_left  = 0;
    gap_left    = 0;
    for (int unsigned i = 0; i < DirRows; i++) text_q.push_back(dir_tab[i]);
    while (text_q.size() < DirRows + RandItems) add_random_text();

    wait (rst_ni === 1'b1);
    while (!text_done) begin
      @(posedge clk_i);
      if (push && !full) begin
        // beat taken: model it and queue what it owes
        decode_byte(data_i.data_byte, data_i.end_of_text);
        if (text_q[sent].chk == Typed) begin
          for (int unsigned k = 0; k < text_q[sent].n_cp; k++) begin
            pending_cps.push_back('{code_point:  (k == 0) ? text_q[sent].cp_a
                                                          : text_q[sent].cp_b,
                                    last_of_run: (k == text_q[sent].n_cp - 1)});
          end
        end else begin
          for (int unsigned k = 0; k < run_n; k++) begin
            pending_cps.push_back('{code_point: run_cp[k], last_of_run: (k == run_n - 1)});
          end
        end
        sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (sent == text_q.size()) begin
        push      <= 1'b0;
        text_done  = 1'b1;
      end else if (gap_left > 0) begin
        push <= 1'b0;
        gap_left--;
      end else begin
        push   <= 1'b1;
        data_i <= {text_q[sent].data_v, text_q[sent].eot};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern steps through five patterns in turn, plus one long hold-off
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned rx_cyc;
    int unsigned hold_left;
    bit          held;
    out_beat_t   want;
    pop       <= 1'b0;
    rx_cyc     = 0;
    hold_left  = 0;
    held       = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_cps.size() == 0) begin
          $error("code point %h arrived with nothing owed", data_o.code_point);
          err_cnt++;
        end else begin
          want = pending_cps.pop_front();
          if (data_o.code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, data_o.code_point);
            err_cnt++;
          end
          if (data_o.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, data_o.last_of_run);
            err_cnt++;
          end
        end
      end
      // hold off well into the random text so the queue fills and full rises
      if (!held && sent >= DirRows + 200) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      rx_cyc++;
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        case ((rx_cyc / 150) % 5)
          0: pop <= 1'b1;
          1: pop <= rx_cyc[0];
          2: pop <= ($urandom_range(0, 3) != 0);
          3: pop <= (rx_cyc[1:0] == 2'b00);
          default: pop <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // end of run: all text sent, all code points in, then a short drain
  // ---------------------------------------------------------------------------

  initial begin
    wait (text_done);
    wait (pending_cps.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== utf8_decoder_with_replacement.f =====
rtl/core/u8d_pkg.sv
rtl/core/u8d_front.sv
rtl/core/u8d_queue.sv
rtl/core/u8d_back.sv
rtl/core/utf8_decoder_with_replacement.sv
rtl/core/u8d_checker.sv
tb/tb.sv
